@@ rtl/backoff_retry_timer_queue_unit_macros.svh @@
// Assertion macros for the backoff retry timer queue.
`ifndef BACKOFF_RETRY_TIMER_QUEUE_UNIT_MACROS_SVH
`define BACKOFF_RETRY_TIMER_QUEUE_UNIT_MACROS_SVH

// Clocked check, muted while reset is asserted.
`define BRTQ_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Clocked check, active during reset as well.
`define BRTQ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ rtl/brtq_pkg.sv @@
`default_nettype none
package brtq_pkg;

    localparam int QUEUE_DEPTH  = 16;
    localparam int TASK_ID_BITS = 16;
    localparam int TIME_BITS    = 32;
    localparam int ARR_BITS     = 32;

    localparam int IDX_W  = $clog2(QUEUE_DEPTH);
    localparam int OCC_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int CNT_W  = 8;
    localparam int BASE_W = 16;
    localparam int MAX_W  = 20;
    localparam int CAP_W  = 4;
    localparam int VERD_W = 2;
    localparam int PEND_W = 5;
    localparam int SHL_W  = BASE_W + (1 << CAP_W) - 1;

    localparam int IN_FIELDS_W  = TASK_ID_BITS + 2 * CNT_W;
    localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = TASK_ID_BITS + 2 * CNT_W + VERD_W + PEND_W;
    localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;
    localparam int VERD_LSB     = TASK_ID_BITS + 2 * CNT_W;
    localparam int PEND_LSB     = VERD_LSB + VERD_W;

    localparam int APB_DW = 32;
    localparam int APB_AW = 4;
    localparam int REG_W  = APB_AW - 2;

    localparam logic [REG_W-1:0] REG_BASE_DELAY = REG_W'(0);
    localparam logic [REG_W-1:0] REG_MAX_DELAY  = REG_W'(1);
    localparam logic [REG_W-1:0] REG_SHIFT_CAP  = REG_W'(2);

    localparam logic [BASE_W-1:0] BASE_DELAY_RST = BASE_W'(2000);
    localparam logic [MAX_W-1:0]  MAX_DELAY_RST  = MAX_W'(60000);
    localparam logic [CAP_W-1:0]  SHIFT_CAP_RST  = CAP_W'(10);

    localparam logic OP_SCHEDULE = 1'b0;
    localparam logic OP_TICK     = 1'b1;

    localparam logic [VERD_W-1:0] VERDICT_REQUEUE  = VERD_W'(0);
    localparam logic [VERD_W-1:0] VERDICT_FAILED   = VERD_W'(1);
    localparam logic [VERD_W-1:0] VERDICT_REJECTED = VERD_W'(2);

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_DEPTH - 1);

    typedef struct packed {
        logic [TIME_BITS-1:0]    deadline;
        logic [ARR_BITS-1:0]     arrival;
        logic [TASK_ID_BITS-1:0] task_id;
        logic [CNT_W-1:0]        count;
        logic [CNT_W-1:0]        limit;
    } t_slot;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCHED,
        ST_STORE,
        ST_REPLY,
        ST_SCAN,
        ST_EMIT
    } t_state;

endpackage
`default_nettype wire

@@ rtl/backoff_retry_timer_queue_unit.sv @@
`default_nettype none
// Schedule request: a word passes the SCHED state, then STORE or REPLY, before the next word is
// taken; a fail/reject word is registered in REPLY (plus output stalls). Tick: each scan pass reads
// the slot memory one entry a cycle, then EMIT sends the best due entry; a tick repeats scan and
// emit for each due entry before the next word is taken (plus output stalls).
// Reset (synchronous, active low) empties the store, zeroes clock, arrival counter and
// occupancy, and loads base_delay 2000, max_delay 60000, shift_cap 10.
module backoff_retry_timer_queue_unit
    import brtq_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [IN_DATA_W-1:0]  s_tdata,  // task_id, count, limit
    input  wire logic [0:0]            s_tuser,  // operation
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [OUT_DATA_W-1:0]      m_tdata,  // task_id, count, limit, verdict, pending
    output logic                       m_tlast,  // last
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_AW-1:0]     paddr,
    input  wire logic [APB_DW-1:0]     pwdata,
    output logic [APB_DW-1:0]          prdata,
    output logic                       pready
);

    t_state r_state, n_state;

    logic [BASE_W-1:0]       r_base;
    logic [MAX_W-1:0]        r_max;
    logic [CAP_W-1:0]        r_cap;
    logic [TIME_BITS-1:0]    r_time;
    logic [ARR_BITS-1:0]     r_arrival;
    logic [OCC_W-1:0]        r_occ;
    logic [QUEUE_DEPTH-1:0]  r_valid;

    t_slot                   r_mem [QUEUE_DEPTH];
    t_slot                   r_rd;
    t_slot                   r_best;
    logic [IDX_W-1:0]        r_best_idx;
    logic                    r_best_found;
    logic [OCC_W-1:0]        r_due_cnt;
    logic                    r_first;
    logic [IDX_W-1:0]        r_scan_idx;
    logic                    r_issue;
    logic                    r_cmp_vld;
    logic [IDX_W-1:0]        r_cmp_idx;

    logic [TASK_ID_BITS-1:0] r_in_task;
    logic [CNT_W-1:0]        r_in_cnt;
    logic [CNT_W-1:0]        r_in_lim;
    logic [VERD_W-1:0]       r_in_verdict;
    logic [MAX_W-1:0]        r_delay;

    logic                    r_out_valid;
    logic [OUT_DATA_W-1:0]   r_out_data;
    logic                    r_out_last;

    logic                    accept_in;
    logic                    out_free;
    logic                    out_load;
    logic                    cfg_wr;
    logic [REG_W-1:0]        cfg_reg;
    logic                    free_found;
    logic [IDX_W-1:0]        free_idx;
    logic [CAP_W-1:0]        shamt;
    logic [SHL_W-1:0]        shifted;
    logic [MAX_W-1:0]        delay;
    logic                    at_limit;
    logic [TIME_BITS-1:0]    due_diff;
    logic [TIME_BITS-1:0]    dl_diff;
    logic [ARR_BITS-1:0]     arr_diff;
    logic                    c_due;
    logic                    dl_tie;
    logic                    arr_first;
    logic                    c_first;
    logic                    take;
    logic                    best_last;
    logic [VERD_W-1:0]       best_verdict;

    assign s_tready  = (r_state == ST_IDLE);
    assign accept_in = s_tvalid && s_tready;
    assign out_free  = !r_out_valid || m_tready;
    assign out_load  = out_free && ((r_state == ST_REPLY)
                                    || (r_state == ST_EMIT && r_best_found));
    assign m_tvalid  = r_out_valid;
    assign m_tdata   = r_out_data;
    assign m_tlast   = r_out_last;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_reg = paddr[APB_AW-1:2];

    always_comb begin
        case (cfg_reg)
            REG_BASE_DELAY: prdata = APB_DW'(r_base);
            REG_MAX_DELAY:  prdata = APB_DW'(r_max);
            REG_SHIFT_CAP:  prdata = APB_DW'(r_cap);
            default:        prdata = '0;
        endcase
    end

    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = QUEUE_DEPTH - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                free_found = 1'b1;
                free_idx   = IDX_W'(i);
            end
        end
    end

    assign at_limit = (r_in_cnt >= r_in_lim);
    assign shamt    = (r_in_cnt < CNT_W'(r_cap)) ? r_in_cnt[CAP_W-1:0] : r_cap;
    assign shifted  = SHL_W'(r_base) << shamt;
    assign delay    = (shifted < SHL_W'(r_max)) ? shifted[MAX_W-1:0] : r_max;

    // Shared compare unit: due test and release order against the current best.
    assign due_diff  = r_time - r_rd.deadline;
    assign dl_diff   = r_best.deadline - r_rd.deadline;
    assign arr_diff  = r_best.arrival - r_rd.arrival;
    assign c_due     = r_valid[r_cmp_idx] && !due_diff[TIME_BITS-1];
    assign dl_tie    = (dl_diff == '0) || (dl_diff == {1'b1, {(TIME_BITS-1){1'b0}}});
    assign arr_first = !arr_diff[ARR_BITS-1] && (arr_diff != '0);
    assign c_first   = dl_tie ? arr_first : !dl_diff[TIME_BITS-1];
    assign take      = (r_state == ST_SCAN) && r_cmp_vld && c_due
                       && (!r_best_found || c_first);

    assign best_last    = (r_due_cnt == OCC_W'(1));
    assign best_verdict = (r_best.count >= r_best.limit) ? VERDICT_FAILED : VERDICT_REQUEUE;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept_in) begin
                    n_state = (s_tuser[0] == OP_TICK) ? ST_SCAN : ST_SCHED;
                end
            end
            ST_SCHED: begin
                n_state = (at_limit || !free_found) ? ST_REPLY : ST_STORE;
            end
            ST_STORE: begin
                n_state = ST_IDLE;
            end
            ST_REPLY: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            ST_SCAN: begin
                if (r_cmp_vld && r_cmp_idx == LAST_IDX) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (!r_best_found) begin
                    n_state = ST_IDLE;
                end else if (out_free) begin
                    n_state = best_last ? ST_IDLE : ST_SCAN;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base       <= BASE_DELAY_RST;
            r_max        <= MAX_DELAY_RST;
            r_cap        <= SHIFT_CAP_RST;
            r_time       <= '0;
            r_arrival    <= '0;
            r_occ        <= '0;
            r_valid      <= '0;
            r_out_valid  <= 1'b0;
            r_scan_idx   <= '0;
            r_issue      <= 1'b0;
            r_cmp_vld    <= 1'b0;
            r_best_found <= 1'b0;
            r_due_cnt    <= '0;
            r_first      <= 1'b0;
        end else begin
            if (cfg_wr) begin
                case (cfg_reg)
                    REG_BASE_DELAY: r_base <= pwdata[BASE_W-1:0];
                    REG_MAX_DELAY:  r_max  <= pwdata[MAX_W-1:0];
                    REG_SHIFT_CAP:  r_cap  <= pwdata[CAP_W-1:0];
                    default: ;
                endcase
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_tready) begin
                r_out_valid <= 1'b0;
            end
            r_cmp_vld <= (r_state == ST_SCAN) && r_issue;
            case (r_state)
                ST_IDLE: begin
                    if (accept_in && s_tuser[0] == OP_TICK) begin
                        r_time       <= r_time + 1'b1;
                        r_scan_idx   <= '0;
                        r_issue      <= 1'b1;
                        r_best_found <= 1'b0;
                        r_due_cnt    <= '0;
                        r_first      <= 1'b1;
                    end
                end
                ST_STORE: begin
                    r_valid[free_idx] <= 1'b1;
                    r_occ             <= r_occ + 1'b1;
                    r_arrival         <= r_arrival + 1'b1;
                end
                ST_SCAN: begin
                    if (r_issue) begin
                        if (r_scan_idx == LAST_IDX) begin
                            r_issue <= 1'b0;
                        end else begin
                            r_scan_idx <= r_scan_idx + 1'b1;
                        end
                    end
                    if (take) begin
                        r_best_found <= 1'b1;
                    end
                    if (r_cmp_vld && c_due && r_first) begin
                        r_due_cnt <= r_due_cnt + 1'b1;
                    end
                end
                ST_EMIT: begin
                    if (r_best_found && out_free) begin
                        r_valid[r_best_idx] <= 1'b0;
                        r_occ               <= r_occ - 1'b1;
                        r_due_cnt           <= r_due_cnt - 1'b1;
                        if (!best_last) begin
                            r_scan_idx   <= '0;
                            r_issue      <= 1'b1;
                            r_best_found <= 1'b0;
                            r_first      <= 1'b0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept_in) begin
            r_in_task <= s_tdata[TASK_ID_BITS-1:0];
            r_in_cnt  <= s_tdata[TASK_ID_BITS +: CNT_W];
            r_in_lim  <= s_tdata[TASK_ID_BITS + CNT_W +: CNT_W];
        end
        case (r_state)
            ST_SCHED: begin
                r_delay      <= delay;
                r_in_verdict <= at_limit ? VERDICT_FAILED : VERDICT_REJECTED;
            end
            ST_STORE: begin
                r_mem[free_idx] <= '{deadline: r_time + TIME_BITS'(r_delay),
                                     arrival:  r_arrival,
                                     task_id:  r_in_task,
                                     count:    r_in_cnt,
                                     limit:    r_in_lim};
            end
            ST_REPLY: begin
                if (out_free) begin
                    r_out_data <= OUT_DATA_W'({PEND_W'(r_occ), r_in_verdict,
                                               r_in_lim, r_in_cnt, r_in_task});
                    r_out_last <= 1'b1;
                end
            end
            ST_SCAN: begin
                if (r_issue) begin
                    r_rd      <= r_mem[r_scan_idx];
                    r_cmp_idx <= r_scan_idx;
                end
                if (take) begin
                    r_best     <= r_rd;
                    r_best_idx <= r_cmp_idx;
                end
            end
            ST_EMIT: begin
                if (r_best_found && out_free) begin
                    r_out_data <= OUT_DATA_W'({PEND_W'(r_occ - 1'b1), best_verdict,
                                               r_best.limit, r_best.count,
                                               r_best.task_id});
                    r_out_last <= best_last;
                end
            end
            default: ;
        endcase
    end

endmodule
`default_nettype wire

@@ rtl/brtq_checker.sv @@
`default_nettype none
`include "backoff_retry_timer_queue_unit_macros.svh"
module brtq_checker
    import brtq_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  s_tvalid,
    input  wire logic                  s_tready,
    input  wire logic                  m_tvalid,
    input  wire logic                  m_tready,
    input  wire logic [OUT_DATA_W-1:0] m_tdata,
    input  wire logic                  m_tlast
);

    logic [VERD_W-1:0] verdict;
    logic [PEND_W-1:0] pending;

    assign verdict = m_tdata[VERD_LSB +: VERD_W];
    assign pending = m_tdata[PEND_LSB +: PEND_W];

    `BRTQ_ASSERT(a_out_hold, i_clk, i_rst_n, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast), "output word changed while stalled")
    `BRTQ_ASSERT(a_verdict_code, i_clk, i_rst_n, m_tvalid |-> (verdict == VERDICT_REQUEUE || verdict == VERDICT_FAILED || verdict == VERDICT_REJECTED), "undefined verdict code")
    `BRTQ_ASSERT(a_reject_last, i_clk, i_rst_n, m_tvalid && verdict == VERDICT_REJECTED |-> m_tlast, "rejected word without last")
    `BRTQ_ASSERT(a_pending_range, i_clk, i_rst_n, m_tvalid |-> pending <= PEND_W'(QUEUE_DEPTH), "pending above store depth")
    `BRTQ_ASSERT(a_busy_after_accept, i_clk, i_rst_n, s_tvalid && s_tready |=> !s_tready, "ready held after accepting a word")

endmodule

bind backoff_retry_timer_queue_unit brtq_checker u_brtq_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
`default_nettype wire
